// ===== hdl/calu_pkg.sv =====
// shared types and constants of the cpu alu with flags
package calu_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 3;

    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [7:0] DAA_LIMIT     = 8'h99;
    localparam logic [7:0] DAA_HIGH_ADJ  = 8'h60;
    localparam logic [7:0] DAA_LOW_ADJ   = 8'h06;
    localparam logic [3:0] DAA_NIB_LIMIT = 4'h9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_CP    = 5'd4,
        CMD_AND   = 5'd5,
        CMD_XOR   = 5'd6,
        CMD_OR    = 5'd7,
        CMD_INC   = 5'd8,
        CMD_DEC   = 5'd9,
        CMD_DAA   = 5'd10,
        CMD_CPL   = 5'd11,
        CMD_SCF   = 5'd12,
        CMD_CCF   = 5'd13,
        CMD_RLCA  = 5'd14,
        CMD_RRCA  = 5'd15,
        CMD_RLA   = 5'd16,
        CMD_RRA   = 5'd17,
        CMD_RLC   = 5'd18,
        CMD_RRC   = 5'd19,
        CMD_RL    = 5'd20,
        CMD_RR    = 5'd21,
        CMD_SLA   = 5'd22,
        CMD_SRA   = 5'd23,
        CMD_SWAP  = 5'd24,
        CMD_SRL   = 5'd25,
        CMD_BIT   = 5'd26,
        CMD_RES   = 5'd27,
        CMD_SET   = 5'd28,
        CMD_ADD16 = 5'd29,
        CMD_ADDSP = 5'd30
    } calu_cmd_t;

    typedef struct packed {
        calu_cmd_t          cmd;
        logic [WORD_W-1:0]  operand_a;
        logic [WORD_W-1:0]  operand_b;
        logic [BIT_W-1:0]   bit_index;
        logic               zero;
        logic               subtract;
        logic               half;
        logic               carry;
    } calu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  result;
        logic               writes_result;
        logic               zero;
        logic               subtract;
        logic               half;
        logic               carry;
    } calu_rsp_t;

endpackage

// ===== hdl/calu_core.sv =====
// combinational datapath of the alu: result and flags for one request
module calu_core (
    input  calu_pkg::calu_req_t req,
    output calu_pkg::calu_rsp_t rsp
);
    import calu_pkg::*;

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r;
        logic        ci;
        logic [8:0]  sum9;
        logic [4:0]  nib5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] sext_b;
        logic [7:0]  mask;

        a      = req.operand_a[7:0];
        b      = req.operand_b[7:0];
        r      = a;
        ci     = 1'b0;
        sum9   = '0;
        nib5   = '0;
        sum17  = '0;
        sum13  = '0;
        sext_b = {{8{b[7]}}, b};
        mask   = 8'(8'b1 << req.bit_index);

        rsp.result        = '0;
        rsp.writes_result = 1'b1;
        rsp.zero          = req.zero;
        rsp.subtract      = req.subtract;
        rsp.half          = req.half;
        rsp.carry         = req.carry;

        case (req.cmd)
            CMD_ADD, CMD_ADC: begin
                ci           = (req.cmd == CMD_ADC) ? req.carry : 1'b0;
                sum9         = {1'b0, a} + {1'b0, b} + {8'b0, ci};
                nib5         = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, ci};
                r            = sum9[7:0];
                rsp.result   = {8'b0, r};
                rsp.zero     = (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = nib5[4];
                rsp.carry    = sum9[8];
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                ci                = (req.cmd == CMD_SBC) ? req.carry : 1'b0;
                sum9              = {1'b0, a} - {1'b0, b} - {8'b0, ci};
                nib5              = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, ci};
                r                 = sum9[7:0];
                rsp.result        = {8'b0, r};
                rsp.writes_result = (req.cmd != CMD_CP);
                rsp.zero          = (r == 8'h00);
                rsp.subtract      = 1'b1;
                rsp.half          = nib5[4];
                rsp.carry         = sum9[8];
            end
            CMD_AND, CMD_XOR, CMD_OR: begin
                if (req.cmd == CMD_AND) begin
                    r = a & b;
                end else if (req.cmd == CMD_XOR) begin
                    r = a ^ b;
                end else begin
                    r = a | b;
                end
                rsp.result   = {8'b0, r};
                rsp.zero     = (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = (req.cmd == CMD_AND);
                rsp.carry    = 1'b0;
            end
            CMD_INC: begin
                r            = a + 8'd1;
                rsp.result   = {8'b0, r};
                rsp.zero     = (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = (a[3:0] == 4'hf);
            end
            CMD_DEC: begin
                r            = a - 8'd1;
                rsp.result   = {8'b0, r};
                rsp.zero     = (r == 8'h00);
                rsp.subtract = 1'b1;
                rsp.half     = (r[3:0] == 4'hf);
            end
            CMD_DAA: begin
                if (!req.subtract) begin
                    if (req.carry || (a > DAA_LIMIT)) begin
                        r         = r + DAA_HIGH_ADJ;
                        rsp.carry = 1'b1;
                    end
                    if (req.half || (a[3:0] > DAA_NIB_LIMIT)) begin
                        r = r + DAA_LOW_ADJ;
                    end
                end else begin
                    if (req.carry) begin
                        r = r - DAA_HIGH_ADJ;
                    end
                    if (req.half) begin
                        r = r - DAA_LOW_ADJ;
                    end
                end
                rsp.result = {8'b0, r};
                rsp.zero   = (r == 8'h00);
                rsp.half   = 1'b0;
            end
            CMD_CPL: begin
                rsp.result   = {8'b0, ~a};
                rsp.subtract = 1'b1;
                rsp.half     = 1'b1;
            end
            CMD_SCF, CMD_CCF: begin
                rsp.result        = {8'b0, a};
                rsp.writes_result = 1'b0;
                rsp.subtract      = 1'b0;
                rsp.half          = 1'b0;
                rsp.carry         = (req.cmd == CMD_SCF) ? 1'b1 : ~req.carry;
            end
            CMD_RLCA, CMD_RLC, CMD_RLA, CMD_RL, CMD_SLA: begin
                if (req.cmd == CMD_RLCA || req.cmd == CMD_RLC) begin
                    r = {a[6:0], a[7]};
                end else if (req.cmd == CMD_SLA) begin
                    r = {a[6:0], 1'b0};
                end else begin
                    r = {a[6:0], req.carry};
                end
                rsp.result   = {8'b0, r};
                rsp.zero     = (req.cmd != CMD_RLCA) && (req.cmd != CMD_RLA) && (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = 1'b0;
                rsp.carry    = a[7];
            end
            CMD_RRCA, CMD_RRC, CMD_RRA, CMD_RR, CMD_SRA, CMD_SRL: begin
                if (req.cmd == CMD_RRCA || req.cmd == CMD_RRC) begin
                    r = {a[0], a[7:1]};
                end else if (req.cmd == CMD_SRA) begin
                    r = {a[7], a[7:1]};
                end else if (req.cmd == CMD_SRL) begin
                    r = {1'b0, a[7:1]};
                end else begin
                    r = {req.carry, a[7:1]};
                end
                rsp.result   = {8'b0, r};
                rsp.zero     = (req.cmd != CMD_RRCA) && (req.cmd != CMD_RRA) && (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = 1'b0;
                rsp.carry    = a[0];
            end
            CMD_SWAP: begin
                r            = {a[3:0], a[7:4]};
                rsp.result   = {8'b0, r};
                rsp.zero     = (r == 8'h00);
                rsp.subtract = 1'b0;
                rsp.half     = 1'b0;
                rsp.carry    = 1'b0;
            end
            CMD_BIT: begin
                rsp.result        = {8'b0, a};
                rsp.writes_result = 1'b0;
                rsp.zero          = ~a[req.bit_index];
                rsp.subtract      = 1'b0;
                rsp.half          = 1'b1;
            end
            CMD_RES: begin
                rsp.result = {8'b0, a & ~mask};
            end
            CMD_SET: begin
                rsp.result = {8'b0, a | mask};
            end
            CMD_ADD16: begin
                sum17        = {1'b0, req.operand_a} + {1'b0, req.operand_b};
                sum13        = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
                rsp.result   = sum17[15:0];
                rsp.subtract = 1'b0;
                rsp.half     = sum13[12];
                rsp.carry    = sum17[16];
            end
            CMD_ADDSP: begin
                sum9         = {1'b0, req.operand_a[7:0]} + {1'b0, b};
                nib5         = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};
                rsp.result   = req.operand_a + sext_b;
                rsp.zero     = 1'b0;
                rsp.subtract = 1'b0;
                rsp.half     = nib5[4];
                rsp.carry    = sum9[8];
            end
            default: begin
                rsp.result        = '0;
                rsp.writes_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/cpu_alu_with_flags.sv =====
// top level of the cpu alu with flags: request register, datapath, result register
//
// channel | dir | tdata (low bit up)                                  | tuser
// s_      | in  | operand_a, operand_b, bit_index, zero_in,           | cmd
//         |     | subtract_in, half_in, carry_in, zero pad            |
// m_      | out | result, zero_out, subtract_out, half_out, carry_out | writes_result
//
// one request accepted every cycle while the result side is ready
// the request register and the result register sit around the datapath
// aresetn clears both valid bits, payload registers are not reset
// a stalled result holds in the result register while the request stage still moves
// if it is empty or the result is taken in the same cycle
module cpu_alu_with_flags (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operand_a, operand_b, bit_index, zero_in, subtract_in, half_in, carry_in, pad
    input  logic [calu_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic [calu_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result, zero_out, subtract_out, half_out, carry_out, pad
    output logic [calu_pkg::M_DATA_W-1:0]   m_tdata,
    // writes_result
    output logic                            m_tuser
);
    import calu_pkg::*;

    logic      req_valid_reg;
    logic      req_valid_next;
    calu_req_t req_reg;
    calu_req_t req_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    calu_rsp_t rsp_reg;
    calu_rsp_t rsp_next;
    calu_rsp_t rsp_comb;
    logic      rsp_load;
    logic      req_load;

    assign rsp_load = req_valid_reg && (!rsp_valid_reg || m_tready);
    assign s_tready = !req_valid_reg || rsp_load;
    assign req_load = s_tvalid && s_tready;

    always_comb begin
        req_next           = req_reg;
        req_valid_next     = req_valid_reg;
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        if (rsp_load) begin
            rsp_next = rsp_comb;
        end
        if (rsp_load) begin
            rsp_valid_next = 1'b1;
        end else if (m_tready) begin
            rsp_valid_next = 1'b0;
        end
        if (req_load) begin
            req_next.cmd       = calu_cmd_t'(s_tuser);
            req_next.operand_a = s_tdata[15:0];
            req_next.operand_b = s_tdata[31:16];
            req_next.bit_index = s_tdata[34:32];
            req_next.zero      = s_tdata[35];
            req_next.subtract  = s_tdata[36];
            req_next.half      = s_tdata[37];
            req_next.carry     = s_tdata[38];
            req_valid_next     = 1'b1;
        end else if (rsp_load) begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    calu_core u_core (
        .req (req_reg),
        .rsp (rsp_comb)
    );

    assign m_tvalid = rsp_valid_reg;
    assign m_tuser  = rsp_reg.writes_result;
    assign m_tdata  = {4'b0, rsp_reg.carry, rsp_reg.half, rsp_reg.subtract, rsp_reg.zero,
                       rsp_reg.result};

endmodule

// ===== hdl/calu_checker.sv =====
// port-level checks of the cpu alu with flags and their bind
module calu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [calu_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);
    import calu_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a free result side never blocks new requests
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("request blocked while result side ready");

    // an accepted request reaches the result when the result side keeps up
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted request did not reach result");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:20] == 4'b0))
        else $error("result pad bits not zero");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (.*);
